/* rtl/jtc_pkg.sv */
// Shared types, constants and character classes for the JSON token classifier.
package jtc_pkg;

   localparam int MAX_LINES   = 12;
   localparam int MAX_SEGMENT = 512;
   localparam int SEG_W       = $clog2(MAX_SEGMENT + 1);
   localparam int LINE_W      = $clog2(MAX_LINES + 1);
   localparam int LEN_W       = 10;
   localparam int LIDX_W      = 4;
   localparam int MAX_EMIT    = 3;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_BLANK   = 3'd0;
   localparam kind_type KIND_STRING  = 3'd1;
   localparam kind_type KIND_NUMBER  = 3'd2;
   localparam kind_type KIND_KEYWORD = 3'd3;
   localparam kind_type KIND_PUNCT   = 3'd4;
   localparam kind_type KIND_WORD    = 3'd5;
   localparam kind_type KIND_OTHER   = 3'd6;
   localparam kind_type KIND_BREAK   = 3'd7;
   localparam kind_type KIND_NONE    = 3'd7;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_DOT    = 8'h2E;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [LEN_W-1:0]  length;
      logic [LIDX_W-1:0] line_index;
      logic              final_res;
   } rsp_type;

   // results of one accepted transaction, slot 0 first
   typedef struct packed {
      logic [1:0]                cnt;
      rsp_type [MAX_EMIT-1:0]    slot;
   } emit_type;

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      return c == "{" || c == "}" || c == "[" || c == "]" || c == ":" || c == ",";
   endfunction

   function automatic logic is_num_cont(logic [7:0] c);
      return is_digit(c) || c == CH_DOT || c == "e" || c == "E" || c == CH_PLUS ||
             c == CH_MINUS;
   endfunction

endpackage

/* rtl/json_token_classifier.sv */
// Top level of the JSON token classifier: lexer front end feeding a result queue.
// Accepts one byte per cycle. Each byte gives zero to three results (token kind, length,
// line index, final flag), which land in an 8-entry queue; the output side delivers one
// result per cycle while not stalled, from the clock after the byte is taken. req_stall
// rises while fewer than three queue entries are free, so the sustained input rate is
// one byte per cycle as long as the bytes average at most one result each, and is
// otherwise set by the one-result-per-cycle output port. After the twelfth line break,
// a zero byte or a byte marked last, bytes are still taken but give no results until reset.
module json_token_classifier import jtc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   emit_type push;
   logic     space_ok;

   jtc_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .space_ok  (space_ok),
      .push      (push)
   );

   jtc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

/* rtl/jtc_lexer.sv */
// Front end: accepts bytes, runs the lexer state and produces up to three results per byte.
module jtc_lexer import jtc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  req_type  req_data,
   output logic     req_stall,
   input  logic     space_ok,
   output emit_type push
);

   typedef struct packed {
      kind_type         tk;
      logic [SEG_W-1:0] tl;
      logic             bo;
      logic             mp;
      logic [2:0]       km;
      logic [SEG_W-1:0] seg;
      logic [LINE_W-1:0] lc;
      logic             fin;
   } lex_state_type;

   typedef struct packed {
      lex_state_type s;
      emit_type      e;
   } step_type;

   localparam lex_state_type LEX_RESET = '{
      tk: KIND_NONE, tl: '0, bo: 1'b0, mp: 1'b0, km: 3'b111,
      seg: '0, lc: '0, fin: 1'b0
   };

   function automatic logic [7:0] kw_true_char(logic [1:0] p);
      logic [7:0] r;
      case (p)
         2'd0: r = "t";
         2'd1: r = "r";
         2'd2: r = "u";
         default: r = "e";
      endcase
      return r;
   endfunction

   function automatic logic [7:0] kw_null_char(logic [1:0] p);
      logic [7:0] r;
      case (p)
         2'd0: r = "n";
         2'd1: r = "u";
         default: r = "l";
      endcase
      return r;
   endfunction

   function automatic logic [7:0] kw_false_char(logic [2:0] p);
      logic [7:0] r;
      case (p)
         3'd0: r = "f";
         3'd1: r = "a";
         3'd2: r = "l";
         3'd3: r = "s";
         default: r = "e";
      endcase
      return r;
   endfunction

   function automatic logic [2:0] kw_match(logic [2:0] km, logic [7:0] c,
                                           logic [SEG_W-1:0] pos);
      logic [2:0] k;
      k = km;
      if (!(pos < SEG_W'(4) && c == kw_true_char(pos[1:0]))) k[0] = 1'b0;
      if (!(pos < SEG_W'(4) && c == kw_null_char(pos[1:0]))) k[1] = 1'b0;
      if (!(pos < SEG_W'(5) && c == kw_false_char(pos[2:0]))) k[2] = 1'b0;
      return k;
   endfunction

   function automatic step_type emit(step_type t, kind_type k, logic [SEG_W-1:0] len);
      step_type r;
      rsp_type  x;
      r = t;
      x.kind       = k;
      x.length     = LEN_W'(len);
      x.line_index = LIDX_W'(t.s.lc);
      x.final_res  = 1'b0;
      case (t.e.cnt)
         2'd0: begin
            r.e.slot[0] = x;
            r.e.cnt = 2'd1;
         end
         2'd1: begin
            r.e.slot[1] = x;
            r.e.cnt = 2'd2;
         end
         2'd2: begin
            r.e.slot[2] = x;
            r.e.cnt = 2'd3;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic step_type flush_tok(step_type t);
      step_type r;
      kind_type k;
      r = t;
      k = t.s.tk;
      if (t.s.mp) begin
         r = emit(r, KIND_OTHER, SEG_W'(1));
         r.s.mp = 1'b0;
      end else if (t.s.tk != KIND_NONE) begin
         if (k == KIND_WORD && ((t.s.tl == SEG_W'(4) && t.s.km[1:0] != 2'b00) ||
                                (t.s.tl == SEG_W'(5) && t.s.km[2]))) begin
            k = KIND_KEYWORD;
         end
         r = emit(r, k, t.s.tl);
         r.s.tk = KIND_NONE;
      end
      r.s.tl = '0;
      return r;
   endfunction

   function automatic step_type start_tok(step_type t, logic [7:0] c);
      step_type r;
      r = t;
      r.s.tl = SEG_W'(1);
      if (is_blank(c)) begin
         r.s.tk = KIND_BLANK;
      end else if (c == CH_QUOTE) begin
         r.s.tk = KIND_STRING;
         r.s.bo = 1'b0;
      end else if (is_digit(c)) begin
         r.s.tk = KIND_NUMBER;
      end else if (c == CH_MINUS) begin
         r.s.mp = 1'b1;
         r.s.tl = '0;
      end else if (is_letter(c)) begin
         r.s.tk = KIND_WORD;
         r.s.km = kw_match(3'b111, c, '0);
      end else begin
         r.s.tl = '0;
         r = emit(r, is_punct(c) ? KIND_PUNCT : KIND_OTHER, SEG_W'(1));
      end
      return r;
   endfunction

   function automatic step_type line_brk(step_type t);
      step_type r;
      r = flush_tok(t);
      r = emit(r, KIND_BREAK, '0);
      r.s.seg = '0;
      r.s.lc = r.s.lc + 1'b1;
      if (r.s.lc >= LINE_W'(MAX_LINES)) r.s.fin = 1'b1;
      return r;
   endfunction

   lex_state_type state_ff, state_in;
   step_type      t;
   logic          acc;
   logic          do_flush, do_start, brk;
   logic [7:0]    c;

   assign acc       = req_valid & space_ok;
   assign req_stall = ~space_ok;
   assign c         = req_data.ch;

   always_comb begin
      t.s = state_ff;
      t.e = '0;
      do_flush = 1'b0;
      do_start = 1'b0;
      brk = 1'b0;
      if (!t.s.fin) begin
         if (c == CH_NUL) begin
            brk = t.s.seg != '0;
         end else if (c == CH_LF) begin
            brk = 1'b1;
         end else begin
            if (t.s.mp) begin
               if (is_digit(c)) begin
                  t.s.mp = 1'b0;
                  t.s.tk = KIND_NUMBER;
                  t.s.tl = SEG_W'(2);
               end else begin
                  do_flush = 1'b1;
                  do_start = 1'b1;
               end
            end else begin
               case (t.s.tk)
                  KIND_BLANK: begin
                     if (is_blank(c)) t.s.tl = t.s.tl + 1'b1;
                     else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                     end
                  end
                  KIND_STRING: begin
                     t.s.tl = t.s.tl + 1'b1;
                     if (c == CH_QUOTE && !t.s.bo) do_flush = 1'b1;
                     else if (c == CH_BSLASH) t.s.bo = ~t.s.bo;
                     else t.s.bo = 1'b0;
                  end
                  KIND_NUMBER: begin
                     if (is_num_cont(c)) t.s.tl = t.s.tl + 1'b1;
                     else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                     end
                  end
                  KIND_WORD: begin
                     if (is_letter(c)) begin
                        t.s.km = kw_match(t.s.km, c, t.s.tl);
                        t.s.tl = t.s.tl + 1'b1;
                     end else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                     end
                  end
                  default: begin
                     do_start = 1'b1;
                  end
               endcase
            end
            if (do_flush) t = flush_tok(t);
            if (do_start) t = start_tok(t, c);
            t.s.seg = t.s.seg + 1'b1;
            brk = t.s.seg >= SEG_W'(MAX_SEGMENT);
         end
         if (!brk && c != CH_NUL && req_data.last && t.s.seg != '0) brk = 1'b1;
         if (brk) t = line_brk(t);
         if (req_data.last || c == CH_NUL) t.s.fin = 1'b1;
         if (t.s.fin) begin
            case (t.e.cnt)
               2'd1: t.e.slot[0].final_res = 1'b1;
               2'd2: t.e.slot[1].final_res = 1'b1;
               2'd3: t.e.slot[2].final_res = 1'b1;
               default: ;
            endcase
         end
      end
      state_in = acc ? t.s : state_ff;
      push     = acc ? t.e : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LEX_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   a_quiet_after_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff.fin |-> push.cnt == 2'd0)
      else $error("results produced after finish");

   a_last_finishes: assert property (@(posedge clock) disable iff (reset)
      (acc && req_data.last && !state_ff.fin) |=> state_ff.fin)
      else $error("last byte did not finish the buffer");

   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.lc <= LINE_W'(MAX_LINES))
      else $error("line count beyond limit");

endmodule

/* rtl/jtc_queue.sv */
// Back end: result queue taking up to three results per cycle and delivering one per cycle when not stalled.
module jtc_queue import jtc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  emit_type push,
   output logic     space_ok,
   output logic     rsp_valid,
   output rsp_type  rsp_data,
   input  logic     rsp_stall
);

   rsp_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  head_ff, head_in;
   logic [QPTR_W-1:0]  tail_ff, tail_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               pop;

   assign space_ok  = count_ff <= QCNT_W'(QUEUE_DEPTH - MAX_EMIT);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[head_ff];
   assign pop       = rsp_valid & ~rsp_stall;

   always_comb begin
      head_in  = head_ff + QPTR_W'(pop);
      tail_in  = tail_ff + QPTR_W'(push.cnt);
      count_in = count_ff + QCNT_W'(push.cnt) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_EMIT; i++) begin
         if (2'(i) < push.cnt) begin
            mem_ff[tail_ff + QPTR_W'(i)] <= push.slot[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.cnt != 2'd0 |-> space_ok)
      else $error("push into queue without room");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result transaction changed");

endmodule

/* tb/sv/json_token_classifier_test.sv */
// Self-checking testbench for the JSON token classifier: directed byte table, then random token streams.
module json_token_classifier_test import jtc_pkg::*; ();

   localparam int RAND_ITEMS  = 430;
   localparam int HOLD_CYCLES = 200;
   localparam int RUN_LIMIT   = 2_000_000;

   localparam logic [31:0] KW_TRUE  = "true";
   localparam logic [31:0] KW_NULL  = "null";
   localparam logic [39:0] KW_FALSE = "false";

   typedef enum int {
      END_LINE_LIMIT,
      END_NUL_OPEN,
      END_NUL_EMPTY,
      END_LAST_BYTE,
      END_LAST_LF
   } finish_mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       pinned;
      rsp_type    want;
   } byte_item_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall = 1'b0;

   // lexer state as it stands after reset
   kind_type   lex_kind   = KIND_NONE;
   logic [9:0] lex_len    = '0;
   logic       bs_odd     = 1'b0;
   logic       minus_wait = 1'b0;
   logic [2:0] kw_mask    = 3'b111;
   logic [9:0] seg_cnt    = '0;
   logic [3:0] line_cnt   = '0;
   logic       done       = 1'b0;

   rsp_type       step_out[$];
   rsp_type       pending_tokens[$];
   logic [7:0]    tok_q[$];
   byte_item_type dir_tbl[$];
   rsp_type       got_tok;
   rsp_type       want_tok;
   int            fail_cnt  = 0;
   bit            calm      = 1'b0;
   bit            hold_go   = 1'b0;
   bit            hold_done = 1'b0;

   json_token_classifier DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   function automatic logic is_dig_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha_ch(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_space_ch(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic void emit_tok(kind_type k, logic [9:0] n);
      rsp_type r;
      if (step_out.size() < MAX_EMIT) begin
         r.kind       = k;
         r.length     = n;
         r.line_index = line_cnt;
         r.final_res  = 1'b0;
         step_out.push_back(r);
      end
   endfunction

   function automatic void match_kw(logic [7:0] c, int p);
      if (p >= 4 || c != KW_TRUE[8*(3-p) +: 8]) kw_mask[0] = 1'b0;
      if (p >= 4 || c != KW_NULL[8*(3-p) +: 8]) kw_mask[1] = 1'b0;
      if (p >= 5 || c != KW_FALSE[8*(4-p) +: 8]) kw_mask[2] = 1'b0;
   endfunction

   function automatic void flush_tok();
      kind_type k;
      if (minus_wait) begin
         emit_tok(KIND_OTHER, 10'd1);
         minus_wait = 1'b0;
      end else if (lex_kind != KIND_NONE) begin
         k = lex_kind;
         if (k == KIND_WORD && ((lex_len == 4 && kw_mask[1:0] != 2'b00) ||
                                (lex_len == 5 && kw_mask[2])))
            k = KIND_KEYWORD;
         emit_tok(k, lex_len);
         lex_kind = KIND_NONE;
      end
      lex_len = '0;
   endfunction

   function automatic void end_line();
      flush_tok();
      emit_tok(KIND_BREAK, 10'd0);
      seg_cnt = '0;
      line_cnt++;
      if (line_cnt >= MAX_LINES) done = 1'b1;
   endfunction

   function automatic void open_tok(logic [7:0] c);
      lex_len = 10'd1;
      if (is_space_ch(c)) begin
         lex_kind = KIND_BLANK;
      end else if (c == CH_QUOTE) begin
         lex_kind = KIND_STRING;
         bs_odd   = 1'b0;
      end else if (is_dig_ch(c)) begin
         lex_kind = KIND_NUMBER;
      end else if (c == CH_MINUS) begin
         minus_wait = 1'b1;
         lex_len    = '0;
      end else if (is_alpha_ch(c)) begin
         lex_kind = KIND_WORD;
         kw_mask  = 3'b111;
         match_kw(c, 0);
      end else begin
         lex_len = '0;
         if (c == "{" || c == "}" || c == "[" || c == "]" || c == ":" || c == ",")
            emit_tok(KIND_PUNCT, 10'd1);
         else
            emit_tok(KIND_OTHER, 10'd1);
      end
   endfunction

   function automatic void feed_tok(logic [7:0] c);
      logic grow;
      grow = 1'b0;
      if (minus_wait) begin
         minus_wait = 1'b0;
         if (is_dig_ch(c)) begin
            lex_kind = KIND_NUMBER;
            lex_len  = 10'd2;
         end else begin
            emit_tok(KIND_OTHER, 10'd1);
            open_tok(c);
         end
         return;
      end
      case (lex_kind)
         KIND_BLANK:  grow = is_space_ch(c);
         KIND_NUMBER: grow = is_dig_ch(c) || c == CH_DOT || c == "e" || c == "E" ||
                             c == CH_PLUS || c == CH_MINUS;
         KIND_WORD: begin
            grow = is_alpha_ch(c);
            if (grow) match_kw(c, int'(lex_len));
         end
         default: ;
      endcase
      if (lex_kind == KIND_STRING) begin
         lex_len++;
         if (c == CH_QUOTE && !bs_odd) flush_tok();
         else if (c == CH_BSLASH) bs_odd = ~bs_odd;
         else bs_odd = 1'b0;
      end else if (grow) begin
         lex_len++;
      end else begin
         if (lex_kind != KIND_NONE) flush_tok();
         open_tok(c);
      end
   endfunction

   // tokens caused by one accepted byte land in step_out
   function automatic void lex_step(logic [7:0] c, logic l);
      rsp_type r;
      step_out.delete();
      if (done) return;
      if (c == CH_NUL) begin
         if (seg_cnt > 0) end_line();
         done = 1'b1;
      end else if (c == CH_LF) begin
         end_line();
      end else begin
         feed_tok(c);
         seg_cnt++;
         if (seg_cnt >= MAX_SEGMENT) end_line();
      end
      if (!done && l) begin
         if (seg_cnt > 0) end_line();
         done = 1'b1;
      end
      if (done && step_out.size() > 0) begin
         r = step_out[step_out.size()-1];
         r.final_res = 1'b1;
         step_out[step_out.size()-1] = r;
      end
   endfunction

   function automatic void make_token(bit allow_lf);
      int         pick;
      int         n;
      logic [7:0] c;
      string      w;
      string      num_tail;
      string      punct_set;
      num_tail  = "0123456789.eE+-";
      punct_set = "{}[]:,";
      pick = $urandom_range(99);
      if (pick < 12) begin
         n = $urandom_range(4, 1);
         repeat (n) tok_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
      end else if (pick < 27) begin
         tok_q.push_back(CH_QUOTE);
         n = $urandom_range(8);
         repeat (n) begin
            pick = $urandom_range(19);
            if (pick < 5) c = CH_BSLASH;
            else if (pick < 7) c = CH_QUOTE;
            else if (pick < 8) c = $urandom_range(255, 128);
            else c = $urandom_range(126, 32);
            tok_q.push_back(c);
         end
         if ($urandom_range(9) != 0) tok_q.push_back(CH_QUOTE);
      end else if (pick < 45) begin
         if ($urandom_range(9) < 4) tok_q.push_back(CH_MINUS);
         c = 8'h30 + $urandom_range(9);
         tok_q.push_back(c);
         n = $urandom_range(5);
         repeat (n) tok_q.push_back(num_tail[$urandom_range(14)]);
      end else if (pick < 57) begin
         case ($urandom_range(7))
            0: w = "true";
            1: w = "null";
            2: w = "false";
            3: w = "fals";
            4: w = "nulls";
            5: w = "True";
            6: w = "truE";
            default: w = "nul";
         endcase
         for (int i = 0; i < w.len(); i++) tok_q.push_back(w[i]);
      end else if (pick < 70) begin
         n = $urandom_range(9) == 0 ? 10 : $urandom_range(7, 1);
         repeat (n) begin
            c = $urandom_range(1) ? 8'h61 + $urandom_range(25) : 8'h41 + $urandom_range(25);
            tok_q.push_back(c);
         end
      end else if (pick < 82) begin
         tok_q.push_back(punct_set[$urandom_range(5)]);
      end else if (pick < 97) begin
         c = $urandom_range(255, 1);
         if (c == CH_LF && !allow_lf) c = 8'h7F;
         tok_q.push_back(c);
      end else begin
         tok_q.push_back(allow_lf ? CH_LF : CH_SPACE);
      end
   endfunction

   function automatic byte_item_type row(logic [7:0] c, logic l);
      byte_item_type it;
      it      = '0;
      it.ch   = c;
      it.last = l;
      return it;
   endfunction

   function automatic byte_item_type pin(logic [7:0] c, kind_type k, logic [LEN_W-1:0] n,
                                         logic [LIDX_W-1:0] ln);
      byte_item_type it;
      it                 = row(c, 1'b0);
      it.pinned          = 1'b1;
      it.want.kind       = k;
      it.want.length     = n;
      it.want.line_index = ln;
      it.want.final_res  = 1'b0;
      return it;
   endfunction

   task automatic send_item(input byte_item_type it);
      req_type t;
      t.ch   = it.ch;
      t.last = it.last;
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lex_step(it.ch, it.last);
      if (it.pinned) pending_tokens.push_back(it.want);
      else foreach (step_out[i]) pending_tokens.push_back(step_out[i]);
   endtask

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_cnt++;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // receiver: random stalls, one long hold-off, a calm window
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !calm && $urandom_range(99) < 11;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_tok = rsp_data;
         if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, got_tok);
            fail_cnt++;
         end else begin
            want_tok = pending_tokens.pop_front();
            check_field("kind", want_tok.kind, got_tok.kind);
            check_field("length", want_tok.length, got_tok.length);
            check_field("line_index", want_tok.line_index, got_tok.line_index);
            check_field("final_res", want_tok.final_res, got_tok.final_res);
         end
      end
   end

   initial begin
      int              sent;
      int              base;
      finish_mode_type mode;

      dir_tbl.push_back(pin(CH_LF, KIND_BREAK, 10'd0, 4'd0));
      dir_tbl.push_back(pin("{", KIND_PUNCT, 10'd1, 4'd1));
      dir_tbl.push_back(row(CH_QUOTE, 1'b0));
      dir_tbl.push_back(row(CH_BSLASH, 1'b0));
      dir_tbl.push_back(row(CH_QUOTE, 1'b0));
      dir_tbl.push_back(row(CH_QUOTE, 1'b0));
      dir_tbl.push_back(row("n", 1'b0));
      dir_tbl.push_back(row("u", 1'b0));
      dir_tbl.push_back(row("l", 1'b0));
      dir_tbl.push_back(row("l", 1'b0));
      dir_tbl.push_back(row(CH_SPACE, 1'b0));
      dir_tbl.push_back(row(CH_MINUS, 1'b0));
      dir_tbl.push_back(row("9", 1'b0));
      dir_tbl.push_back(row("e", 1'b0));
      dir_tbl.push_back(row(",", 1'b0));
      dir_tbl.push_back(row(CH_MINUS, 1'b0));
      dir_tbl.push_back(row("x", 1'b0));
      dir_tbl.push_back(row(8'hFF, 1'b0));
      dir_tbl.push_back(pin(8'h01, KIND_OTHER, 10'd1, 4'd1));
      dir_tbl.push_back(pin("]", KIND_PUNCT, 10'd1, 4'd1));
      dir_tbl.push_back(row(CH_MINUS, 1'b0));
      dir_tbl.push_back(row(CH_LF, 1'b0));
      dir_tbl.push_back(row(CH_QUOTE, 1'b0));
      dir_tbl.push_back(row(CH_BSLASH, 1'b0));
      dir_tbl.push_back(row(CH_LF, 1'b0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tbl[i]) send_item(dir_tbl[i]);

      // fill one line to the segment limit, then a newline right behind it
      base = line_cnt;
      while (line_cnt == base) begin
         if (tok_q.size() == 0) make_token(1'b0);
         send_item(row(tok_q.pop_front(), 1'b0));
      end
      tok_q.delete();
      send_item(row(CH_LF, 1'b0));

      // newlines stop short of the line limit so the random part runs in full
      sent = 0;
      while (sent < RAND_ITEMS) begin
         make_token(line_cnt < 9);
         while (tok_q.size() != 0) begin
            send_item(row(tok_q.pop_front(), 1'b0));
            sent++;
            hold_go = sent >= 120;
            calm    = sent >= 250 && sent < 330;
         end
      end
      calm = 1'b0;

      mode = finish_mode_type'($urandom_range(4));
      case (mode)
         END_LINE_LIMIT: while (!done) send_item(row(CH_LF, 1'b0));
         END_NUL_OPEN: begin
            if (seg_cnt == 0) send_item(row("a", 1'b0));
            send_item(row(CH_NUL, 1'b0));
         end
         END_NUL_EMPTY: begin
            if (seg_cnt != 0) send_item(row(CH_LF, 1'b0));
            send_item(row(CH_NUL, 1'b0));
         end
         END_LAST_BYTE: send_item(row(8'h21 + $urandom_range(93), 1'b1));
         default: send_item(row(CH_LF, 1'b1));
      endcase

      // finished: everything below must be ignored
      send_item(row(CH_NUL, 1'b1));
      send_item(row(8'hFF, 1'b1));
      repeat (4) send_item(row($urandom_range(255), $urandom_range(1)));
      req_valid <= 1'b0;

      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      if (fail_cnt == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* files.f */
rtl/jtc_pkg.sv
rtl/jtc_lexer.sv
rtl/jtc_queue.sv
rtl/json_token_classifier.sv
tb/sv/json_token_classifier_test.sv
